@@ hw/rtl/lkhf_pkg.sv @@
// Shared types and constants for the line keyword hide filter.
// Holds the beat payload structs, register indexes and the keyword table.
// No dependencies.
`default_nettype none

package lkhf_pkg;

   localparam int unsigned COUNT_BITS   = 24;
   localparam int unsigned UID_BITS     = 32;
   localparam int unsigned SCAN_BITS    = 10;
   localparam int unsigned WINDOW_DEPTH = 7;
   localparam int unsigned CSR_IDX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS = 32;

   localparam logic [UID_BITS-1:0]  MIN_UID_RESET    = 32'd10000;
   localparam logic [SCAN_BITS-1:0] SCAN_LIMIT_RESET = 10'd512;
   localparam logic [SCAN_BITS-1:0] SCAN_MAX         = 10'd1023;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_HIDE_ENABLE = 2'd0,
      CSR_MIN_UID     = 2'd1,
      CSR_SCAN_LIMIT  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0]            ch;
      logic                  first;
      logic                  last;
      logic [COUNT_BITS-1:0] fill_before;
      logic [COUNT_BITS-1:0] fill_after;
      logic [COUNT_BITS-1:0] buffer_size;
      logic [UID_BITS-1:0]   caller_uid;
   } req_type;

   typedef struct packed {
      logic                  hide;
      logic [COUNT_BITS-1:0] count_out;
   } rsp_type;

   // Keyword table: byte 0 is the first character of each keyword.
   localparam int unsigned KEY_NUM = 11;
   localparam int unsigned KEY_MAX = 8;

   localparam int unsigned KEY_LEN [KEY_NUM] = '{6, 6, 7, 4, 6, 7, 8, 3, 8, 6, 7};

   localparam logic [7:0] KEY_TXT [KEY_NUM][KEY_MAX] = '{
      '{8'h6d, 8'h61, 8'h67, 8'h69, 8'h73, 8'h6b, 8'h00, 8'h00},
      '{8'h7a, 8'h79, 8'h67, 8'h69, 8'h73, 8'h6b, 8'h00, 8'h00},
      '{8'h6c, 8'h73, 8'h70, 8'h6f, 8'h73, 8'h65, 8'h64, 8'h00},
      '{8'h72, 8'h69, 8'h72, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h78, 8'h70, 8'h6f, 8'h73, 8'h65, 8'h64, 8'h00, 8'h00},
      '{8'h73, 8'h75, 8'h70, 8'h65, 8'h72, 8'h73, 8'h75, 8'h00},
      '{8'h6b, 8'h69, 8'h6e, 8'h67, 8'h72, 8'h6f, 8'h6f, 8'h74},
      '{8'h2f, 8'h73, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6b, 8'h65, 8'h72, 8'h6e, 8'h65, 8'h6c, 8'h73, 8'h75},
      '{8'h61, 8'h70, 8'h61, 8'h74, 8'h63, 8'h68, 8'h00, 8'h00},
      '{8'h2e, 8'h6d, 8'h61, 8'h67, 8'h69, 8'h73, 8'h6b, 8'h00}
   };

endpackage

`default_nettype wire

@@ hw/rtl/lkhf_match.sv @@
// Keyword matcher: flags a keyword that ends at the incoming byte.
// Compares the byte window against the fixed keyword table in lkhf_pkg.
// Depends on lkhf_pkg.
`default_nettype none

module lkhf_match #(
   parameter int unsigned WINDOW_DEPTH = lkhf_pkg::WINDOW_DEPTH
) (
   input  wire logic [WINDOW_DEPTH-1:0][7:0] window,
   input  wire logic [7:0]                   ch,
   output logic                              hit
);

   logic [lkhf_pkg::KEY_NUM-1:0] key_hit;

   for (genvar k = 0; k < lkhf_pkg::KEY_NUM; k++) begin : g_key
      localparam int unsigned LEN = lkhf_pkg::KEY_LEN[k];
      logic [lkhf_pkg::KEY_MAX-1:0] byte_ok;

      assign byte_ok[0] = (lkhf_pkg::KEY_TXT[k][LEN-1] == ch);
      for (genvar j = 1; j < lkhf_pkg::KEY_MAX; j++) begin : g_byte
         if (j < LEN) begin : g_cmp
            assign byte_ok[j] = (lkhf_pkg::KEY_TXT[k][LEN-1-j] == window[j-1]);
         end else begin : g_pad
            assign byte_ok[j] = 1'b1;
         end
      end
      assign key_hit[k] = &byte_ok;
   end

   assign hit = |key_hit;

endmodule

`default_nettype wire

@@ hw/rtl/line_keyword_hide_filter_top.sv @@
// Top level of the line keyword hide filter: beat handshakes, CSRs, line state.
// Depends on lkhf_pkg and lkhf_match.
`default_nettype none

// Takes one text byte per beat and, on the last byte of a line, returns one
// beat with the hide flag and the fill count to write back. A byte is taken
// each unstalled cycle; the keyword search, the window shift and the line checks
// finish in the cycle the byte is accepted, and the result sits in an output
// register from the next cycle. Input stall is raised only while that output
// register holds a result that the far side is stalling. CSRs may be written
// at any time the block is idle and take effect on the next accepted byte.
module line_keyword_hide_filter_top #(
   parameter int unsigned WINDOW_DEPTH = lkhf_pkg::WINDOW_DEPTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire lkhf_pkg::req_type                     req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output lkhf_pkg::rsp_type                          rsp_data,
   input  wire logic                                  csr_wr_en,
   input  wire logic [lkhf_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [lkhf_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int unsigned CB = lkhf_pkg::COUNT_BITS;
   localparam int unsigned SB = lkhf_pkg::SCAN_BITS;

   logic                         hide_enable_ff;
   logic [lkhf_pkg::UID_BITS-1:0] min_uid_ff;
   logic [SB-1:0]                scan_limit_ff;

   logic [WINDOW_DEPTH-1:0][7:0] window_ff, window_in, window_cur;
   logic                         hit_ff, hit_in, hit_cur;
   logic                         active_ff, active_in, active_cur;
   logic [SB-1:0]                scanned_ff, scanned_in, scanned_cur;
   logic [CB-1:0]                old_ff, old_in, old_cur;
   logic [CB-1:0]                new_ff, new_in, new_cur;
   logic                         rsp_valid_ff, rsp_valid_in;
   lkhf_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic req_fire, rsp_fire, scan_now, match_hit, hide_now;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hide_enable_ff <= 1'b1;
         min_uid_ff     <= lkhf_pkg::MIN_UID_RESET;
         scan_limit_ff  <= lkhf_pkg::SCAN_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (lkhf_pkg::csr_index_type'(csr_index))
            lkhf_pkg::CSR_HIDE_ENABLE: hide_enable_ff <= csr_wdata[0];
            lkhf_pkg::CSR_MIN_UID:     min_uid_ff     <= csr_wdata;
            lkhf_pkg::CSR_SCAN_LIMIT:  scan_limit_ff  <= csr_wdata[SB-1:0];
            lkhf_pkg::CSR_UNUSED:      ;
            default: ;
         endcase
      end
   end

   lkhf_match #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_match (
      .window (window_cur),
      .ch     (req_data.ch),
      .hit    (match_hit)
   );

   always_comb begin
      if (req_data.first) begin
         window_cur  = '0;
         hit_cur     = 1'b0;
         scanned_cur = '0;
         old_cur     = req_data.fill_before;
         new_cur     = req_data.fill_after;
         active_cur  = hide_enable_ff && (req_data.caller_uid >= min_uid_ff)
                       && (req_data.buffer_size != '0)
                       && (req_data.fill_before <= req_data.fill_after)
                       && (req_data.fill_after <= req_data.buffer_size);
      end else begin
         window_cur  = window_ff;
         hit_cur     = hit_ff;
         scanned_cur = scanned_ff;
         old_cur     = old_ff;
         new_cur     = new_ff;
         active_cur  = active_ff;
      end

      scan_now = scanned_cur < scan_limit_ff;
      hit_in   = hit_cur || (scan_now && match_hit);
      if (scan_now) begin
         window_in = {window_cur[WINDOW_DEPTH-2:0], req_data.ch};
      end else begin
         window_in = window_cur;
      end
      scanned_in = (scanned_cur == lkhf_pkg::SCAN_MAX) ? scanned_cur : scanned_cur + 1'b1;
      old_in     = old_cur;
      new_in     = new_cur;
      active_in  = active_cur && !req_data.last;

      hide_now = active_cur && hide_enable_ff && hit_in && (new_cur > old_cur);
      rsp_data_in.hide      = hide_now;
      rsp_data_in.count_out = hide_now ? old_cur : new_cur;

      priority if (req_fire && req_data.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         hit_ff       <= 1'b0;
         active_ff    <= 1'b0;
         scanned_ff   <= '0;
         old_ff       <= '0;
         new_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            window_ff  <= window_in;
            hit_ff     <= hit_in;
            active_ff  <= active_in;
            scanned_ff <= scanned_in;
            old_ff     <= old_in;
            new_ff     <= new_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_data.last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTH
   a_last_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.last |=> rsp_valid_ff)
      else $error("last byte accepted without a result beat");

   a_no_spurious_beat: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_data.last && !req_stall && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result beat raised by a non-last byte");

   a_first_restarts_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.first |=> scanned_ff == {{(SB-1){1'b0}}, 1'b1})
      else $error("scan count not restarted on first byte");

   a_line_closed: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.last |=> !active_ff)
      else $error("line left open after last byte");

   a_hide_rolls_back: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.last && hide_now |=> rsp_data_ff.count_out < new_ff)
      else $error("hidden line not rolled back");
`endif

endmodule

`default_nettype wire

@@ verif/line_keyword_hide_filter_top_tb.sv @@
// Self-checking testbench for line_keyword_hide_filter_top: streams text lines beat by beat,
// predicts each hide verdict and write-back count, and checks every result beat in order.
// Depends on lkhf_pkg and the filter RTL; needs no other file.
module line_keyword_hide_filter_top_tb;
   import lkhf_pkg::*;

   typedef logic [7:0] byte_q[$];

   localparam int unsigned HOLD_CYCLES = 200;
   localparam time RUN_LIMIT = 64'd5000000;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_HIDE_ENABLE;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // predictor copy of the registers and line state
   logic hide_en = 1'b1;
   logic [UID_BITS-1:0] uid_floor = MIN_UID_RESET;
   logic [SCAN_BITS-1:0] scan_cap = SCAN_LIMIT_RESET;
   logic [7:0] history [WINDOW_DEPTH] = '{default: 8'h00};
   logic line_hit = 1'b0;
   logic line_live = 1'b0;
   logic [SCAN_BITS-1:0] bytes_seen = '0;
   logic [COUNT_BITS-1:0] line_old = '0;
   logic [COUNT_BITS-1:0] line_new = '0;

   rsp_type pending_verdicts[$];
   rsp_type due;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int restart_pct = 0;
   int sent_beats = 0;
   int checked_rsps = 0;
   int hidden_rsps = 0;
   int settings_seen = 0;
   int failures = 0;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;

   line_keyword_hide_filter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic keyword_ends_at(input logic [7:0] c);
      logic ok;
      int k, j, n;
      for (k = 0; k < KEY_NUM; k++) begin
         n = KEY_LEN[k];
         ok = (KEY_TXT[k][n-1] == c);
         for (j = 1; j < n; j++)
            if (KEY_TXT[k][n-1-j] != history[j-1]) ok = 1'b0;
         if (ok) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void scan_byte(input req_type b);
      rsp_type v;
      int i;
      if (b.first) begin
         line_old = b.fill_before;
         line_new = b.fill_after;
         line_live = hide_en && (b.caller_uid >= uid_floor) && (b.buffer_size != 0)
                     && (b.fill_before <= b.fill_after) && (b.fill_after <= b.buffer_size);
         line_hit = 1'b0;
         bytes_seen = '0;
         history = '{default: 8'h00};
      end
      if (bytes_seen < scan_cap) begin
         if (keyword_ends_at(b.ch)) line_hit = 1'b1;
         for (i = WINDOW_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
         history[0] = b.ch;
      end
      if (bytes_seen < SCAN_MAX) bytes_seen++;
      if (b.last) begin
         v.hide = line_live && hide_en && line_hit && (line_new > line_old);
         v.count_out = v.hide ? line_old : line_new;
         line_live = 1'b0;
         pending_verdicts.push_back(v);
      end
   endfunction

   // check result beats, drive receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual hide=%0b count=%0h",
                        $time, rsp_data.hide, rsp_data.count_out);
               failures++;
            end else begin
               due = pending_verdicts.pop_front();
               checked_rsps++;
               if (rsp_data.hide) hidden_rsps++;
               if (rsp_data.hide !== due.hide) begin
                  $display("%0t: hide mismatch, expected %0b actual %0b",
                           $time, due.hide, rsp_data.hide);
                  failures++;
               end
               if (rsp_data.count_out !== due.count_out) begin
                  $display("%0t: count_out mismatch, expected %0h actual %0h",
                           $time, due.count_out, rsp_data.count_out);
                  failures++;
               end
            end
         end
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send_beat(input req_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scan_byte(b);
      sent_beats++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_HIDE_ENABLE: hide_en = val[0];
         CSR_MIN_UID:     uid_floor = val;
         CSR_SCAN_LIMIT:  scan_cap = val[SCAN_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic en, input logic [UID_BITS-1:0] floor_uid,
                                 input logic [SCAN_BITS-1:0] cap);
      settle();
      write_reg(CSR_HIDE_ENABLE, {31'($urandom), en});
      write_reg(CSR_MIN_UID, floor_uid);
      write_reg(CSR_SCAN_LIMIT, {22'($urandom), cap});
      settings_seen++;
   endtask

   function automatic req_type text_beat(input logic [7:0] c, input logic f, input logic l);
      req_type b;
      b.ch = c;
      b.first = f;
      b.last = l;
      b.fill_before = 24'($urandom);
      b.fill_after = 24'($urandom);
      b.buffer_size = 24'($urandom);
      b.caller_uid = $urandom;
      return b;
   endfunction

   function automatic byte_q to_bytes(input string s);
      byte_q q;
      int i;
      for (i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic byte_q key_bytes(input int k);
      byte_q q;
      int i;
      for (i = 0; i < KEY_LEN[k]; i++) q.push_back(KEY_TXT[k][i]);
      return q;
   endfunction

   function automatic void place(ref byte_q t, input int at, input byte_q w);
      int i;
      for (i = 0; i < w.size(); i++)
         if (at + i < t.size()) t[at+i] = w[i];
         else t.push_back(w[i]);
   endfunction

   function automatic logic [7:0] filler_byte();
      int r, k;
      r = $urandom_range(99);
      k = $urandom_range(KEY_NUM - 1);
      if (r < 45) return KEY_TXT[k][$urandom_range(KEY_LEN[k] - 1)];
      if (r < 52) return 8'h00;
      return 8'($urandom);
   endfunction

   task automatic pick_header(output logic [COUNT_BITS-1:0] o, n, sz,
                              output logic [UID_BITS-1:0] uid);
      int r;
      r = $urandom_range(99);
      if (r < 80) begin
         sz = ($urandom_range(4) == 0) ? 24'hFFFFFF : 24'($urandom_range(24'hFFFFFF, 1));
         n = ($urandom_range(4) == 0) ? sz : 24'($urandom_range(sz, 0));
         o = (r < 10) ? n : (r < 20) ? 24'h0 : 24'($urandom_range(n, 0));
      end else begin
         o = 24'($urandom);
         n = 24'($urandom);
         sz = (r < 88) ? 24'h0 : 24'($urandom);
      end
      if ($urandom_range(9) < 8)
         uid = uid_floor + $urandom_range(32'hFFFFFFFF - uid_floor, 0);
      else
         uid = (uid_floor == 0) ? $urandom : $urandom_range(uid_floor - 1, 0);
   endtask

   task automatic send_line(input byte_q text, input logic [COUNT_BITS-1:0] o, n, sz,
                            input logic [UID_BITS-1:0] uid);
      req_type b;
      int i;
      for (i = 0; i < text.size(); i++) begin
         b = text_beat(text[i], i == 0, i == text.size() - 1);
         if (i == 0) begin
            b.fill_before = o;
            b.fill_after = n;
            b.buffer_size = sz;
            b.caller_uid = uid;
         end else if ($urandom_range(99) < restart_pct) begin
            b.first = 1'b1;
         end else if (i < text.size() - 1 && $urandom_range(99) < restart_pct) begin
            b.last = 1'b1;
         end
         send_beat(b);
      end
   endtask

   task automatic send_random_line();
      byte_q text, word;
      logic [COUNT_BITS-1:0] o, n, sz;
      logic [UID_BITS-1:0] uid;
      int len, r, k;
      r = $urandom_range(99);
      len = (r < 70) ? $urandom_range(12, 1) : (r < 96) ? $urandom_range(40, 13)
            : $urandom_range(120, 41);
      text = {};
      repeat (len) text.push_back(filler_byte());
      r = $urandom_range(99);
      if (r < 65) begin
         k = $urandom_range(KEY_NUM - 1);
         word = key_bytes(k);
         if (r < 15) word[$urandom_range(word.size() - 1)] = filler_byte();
         place(text, $urandom_range(len - 1), word);
      end
      pick_header(o, n, sz, uid);
      if ($urandom_range(99) < 4)
         send_beat(text_beat(filler_byte(), 1'b0, 1'($urandom_range(1))));
      send_line(text, o, n, sz, uid);
   endtask

   task automatic test_directed_lines();
      req_type b;
      send_line(to_bytes("q"), 24'd5, 24'd9, 24'd20, MIN_UID_RESET);
      send_line(to_bytes("/su"), 24'h0, 24'hFFFFFF, 24'hFFFFFF, MIN_UID_RESET);
      send_line(to_bytes("/su"), 24'd1, 24'd2, 24'd2, MIN_UID_RESET - 1);
      send_line(to_bytes("/su"), 24'd7, 24'd7, 24'd8, 32'hFFFFFFFF);
      // restart a line midway: the window is cleared
      b = text_beat("/", 1'b1, 1'b0);
      b.fill_before = 24'd1;
      b.fill_after = 24'd5;
      b.buffer_size = 24'd9;
      b.caller_uid = 32'd20000;
      send_beat(b);
      send_beat(text_beat("s", 1'b0, 1'b0));
      b.ch = "x";
      b.fill_after = 24'd6;
      send_beat(b);
      send_beat(text_beat("u", 1'b0, 1'b1));
      // bytes with no line opened
      send_beat(text_beat("/", 1'b0, 1'b0));
      send_beat(text_beat("s", 1'b0, 1'b0));
      send_beat(text_beat("u", 1'b0, 1'b1));
   endtask

   task automatic test_scan_limit();
      apply_settings(1'b1, MIN_UID_RESET, 10'd3);
      send_line(to_bytes("/su"), 24'd3, 24'd4, 24'd4, MIN_UID_RESET);
      apply_settings(1'b1, MIN_UID_RESET, 10'd2);
      send_line(to_bytes("/su"), 24'd3, 24'd4, 24'd4, MIN_UID_RESET);
   endtask

   task automatic test_enable_drop();
      req_type b;
      apply_settings(1'b1, MIN_UID_RESET, SCAN_LIMIT_RESET);
      b = text_beat("/", 1'b1, 1'b0);
      b.fill_before = 24'd2;
      b.fill_after = 24'd8;
      b.buffer_size = 24'd8;
      b.caller_uid = MIN_UID_RESET;
      send_beat(b);
      send_beat(text_beat("s", 1'b0, 1'b0));
      settle();
      write_reg(CSR_HIDE_ENABLE, 32'h0);
      send_beat(text_beat("u", 1'b0, 1'b1));
      settle();
      write_reg(CSR_HIDE_ENABLE, 32'h1);
   endtask

   task automatic test_backpressure();
      logic [COUNT_BITS-1:0] o, n, sz;
      logic [UID_BITS-1:0] uid;
      apply_settings(1'b1, 32'h0, SCAN_LIMIT_RESET);
      hold_asked++;
      repeat (40) begin
         pick_header(o, n, sz, uid);
         if ($urandom_range(1)) send_line(to_bytes("/su"), o, n, sz, uid);
         else send_line({filler_byte()}, o, n, sz, uid);
      end
      settle();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int beats);
      int p, target;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      restart_pct = 2;
      for (p = 0; p < 5; p++) begin
         case (p)
            0: apply_settings(1'b1, 32'h0, SCAN_MAX);
            1: apply_settings(1'b1, 32'hFFFFFFFF, 10'($urandom_range(1023, 3)));
            2: apply_settings(1'($urandom_range(1)), $urandom, 10'($urandom_range(1023, 1)));
            3: apply_settings(1'b1, $urandom_range(20000), 10'($urandom_range(16, 4)));
            default: apply_settings(1'b1, $urandom_range(20000), 10'($urandom_range(1)));
         endcase
         if (p == 0) write_reg(CSR_UNUSED, $urandom);
         target = sent_beats + beats / 5;
         while (sent_beats < target) send_random_line();
      end
      restart_pct = 0;
   endtask

   // one line longer than the scan counter can count: a keyword past the
   // saturation point must stay unseen
   task automatic test_long_lines();
      byte_q text;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(1'b1, 32'h0, SCAN_MAX);
      text = {};
      repeat (1040) text.push_back(8'h20);
      place(text, 1030, to_bytes("/su"));
      send_line(text, 24'd10, 24'd20, 24'd30, 32'd5);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_lines();
      test_scan_limit();
      test_enable_drop();
      test_backpressure();
      test_random_traffic(13, 79, 240);
      test_random_traffic(79, 13, 240);
      test_random_traffic(0, 0, 240);
      test_long_lines();
      settle();
      repeat (8) @(posedge clock);
      $display("Streamed %0d text beats over %0d register settings, with stalls and hold-offs.",
               sent_beats, settings_seen);
      $display("Checked %0d result beats, %0d of them hidden lines; %0d mismatches.",
               checked_rsps, hidden_rsps, failures);
      if (failures == 0 && pending_verdicts.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/lkhf_pkg.sv
hw/rtl/lkhf_match.sv
hw/rtl/line_keyword_hide_filter_top.sv
verif/line_keyword_hide_filter_top_tb.sv
